FILE: hdl/kic_pkg.sv
`timescale 1ns / 1ps
// kic_pkg: widths, register indexes and controller/datapath interface types
// for the kept interval complement block. No dependencies.

package kic_pkg;

    // Time value width (microseconds)
    localparam int TW         = 47;
    // Capacity of the range store
    localparam int MAX_RANGES = 16;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    // Stream payload width: two time values, padded to whole bytes
    localparam int DATA_W     = ((2 * TW + 7) / 8) * 8;
    localparam int PAD_W      = DATA_W - 2 * TW;
    localparam int USER_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_KEEP     = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // range transaction accepted
        logic load_last;  // accepted range ends the job
        logic walk;       // consume head entry of the sorted store
        logic flush;      // close the open merged range
        logic tail;       // check the gap up to the window end
        logic close;      // emit final result, clear job state
    } kic_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic cnt_zero;   // store is empty
        logic room;       // a result can be produced this cycle
        logic out_free;   // output register can take a result
    } kic_status_t;

endpackage

FILE: hdl/kept_interval_complement.sv
`timescale 1ns / 1ps
// kept_interval_complement: top level, joins the sequencer and the datapath
// and maps them onto the stream ports. Depends on kic_pkg, kic_ctrl, kic_dp.
//
// Usage:
//   Set window_start, window_end and min_keep on the cfg port while idle.
//   Send removed ranges on the s_ stream, one per transaction; s_tlast marks
//   the last range of a job. Ranges are clipped, and up to 16 non-empty ones
//   are stored in start order; more are dropped and flagged as overflow.
//   Ranges are loaded one per cycle. After the last range the block walks the
//   store one entry per cycle while no result is held up (merging overlaps
//   and emitting gaps), leaves the walk, then handles the open range, the
//   tail gap and the final result in that order, each waiting while the
//   receiver stalls. s_tready stays low from the last range until the final
//   result is in the output register.
//   Results leave on the m_ stream; m_tlast marks the final one of a job and
//   a job that keeps nothing yields one result with m_tuser[0] low.
//   A stalled receiver holds the output register; the walk waits while both
//   the output register and the one-deep pending slot are full.
//   Reset clears the configuration to zero and empties the store.

module kept_interval_complement
    import kic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TW-1:0]        cfg_data,
    // Range input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // range_start, range_end, zero pad
    input  logic                 s_tlast,   // last_range
    // Result output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // kept_start, kept_end, zero pad
    output logic [USER_W-1:0]    m_tuser,   // interval_valid, overflow
    output logic                 m_tlast    // last_result
);

    kic_cmd_t    cmd;
    kic_status_t st;

    logic [TW-1:0] kept_start;
    logic [TW-1:0] kept_end;
    logic          interval_valid;
    logic          overflow;

    kic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    kic_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .range_start    (s_tdata[TW-1:0]),
        .range_end      (s_tdata[2*TW-1:TW]),
        .cmd            (cmd),
        .st             (st),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .kept_start     (kept_start),
        .kept_end       (kept_end),
        .interval_valid (interval_valid),
        .last_result    (m_tlast),
        .overflow       (overflow)
    );

    // Output packing
    assign m_tdata = {{PAD_W{1'b0}}, kept_end, kept_start};
    assign m_tuser = {overflow, interval_valid};

`ifndef SYNTHESIS
    // Final result is only issued into a free output register
    a_close_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> st.out_free)
        else $error("final result issued while output register busy");

    // A nothing-kept result is always the last of its job
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("nothing-kept result not marked last");

    // No range is taken while the store is being walked
    a_no_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk || cmd.flush || cmd.tail) |-> !s_tready)
        else $error("input ready during walk");

    // Store is empty right after a job closes
    a_close_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> st.cnt_zero)
        else $error("store not cleared at job end");
`endif

endmodule

FILE: hdl/kic_ctrl.sv
`timescale 1ns / 1ps
// kic_ctrl: job sequencer for the kept interval complement block.
// Depends on kic_pkg for the command and status types.

module kic_ctrl
    import kic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  kic_status_t st,
    output kic_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_WALK,
        S_FLUSH,
        S_TAIL,
        S_CLOSE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.load_last = 1'b1;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (st.cnt_zero)
                    state_next = S_FLUSH;
                else if (st.room)
                    cmd.walk = 1'b1;
            end
            S_FLUSH:
            begin
                if (st.room)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (st.room)
                begin
                    cmd.tail   = 1'b1;
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (st.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/kic_dp.sv
`timescale 1ns / 1ps
// kic_dp: datapath of the kept interval complement block: config registers,
// sorted range store, merge/gap walk and result registers. Depends on kic_pkg.

module kic_dp
    import kic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TW-1:0]        cfg_data,
    input  logic [TW-1:0]        range_start,
    input  logic [TW-1:0]        range_end,
    input  kic_cmd_t             cmd,
    output kic_status_t          st,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [TW-1:0]        kept_start,
    output logic [TW-1:0]        kept_end,
    output logic                 interval_valid,
    output logic                 last_result,
    output logic                 overflow
);

    // Configuration
    logic [TW-1:0] window_start_reg;
    logic [TW-1:0] window_end_reg;
    logic [TW-1:0] min_keep_reg;

    // Range store, kept sorted by start on insertion
    logic [TW-1:0]    starts_reg [MAX_RANGES];
    logic [TW-1:0]    ends_reg   [MAX_RANGES];
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;

    // Walk state
    logic          have_reg;
    logic [TW-1:0] ms_reg;
    logic [TW-1:0] me_reg;
    logic [TW-1:0] cursor_reg;

    // One-deep pending result, so the final one can be tagged last
    logic          pend_valid_reg;
    logic [TW-1:0] pend_start_reg;
    logic [TW-1:0] pend_end_reg;

    // Output register
    logic          out_valid_reg;
    logic [TW-1:0] out_start_reg;
    logic [TW-1:0] out_end_reg;
    logic          out_ivalid_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    logic [TW-1:0]   clip_start;
    logic [TW-1:0]   clip_end;
    logic            nonempty;
    logic            full;
    logic            store;
    logic [MAX_RANGES-1:0] below;

    logic [TW-1:0] need;
    logic          overlap;
    logic [TW-1:0] gap_target;
    logic          gap_try;
    logic [TW:0]   diff;
    logic          gap_hit;
    logic [TW-1:0] cursor_max;
    logic          out_free;

    // Configuration writes; unused index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
            window_end_reg   <= '0;
            min_keep_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW_START: window_start_reg <= cfg_data;
                REG_WINDOW_END:   window_end_reg   <= cfg_data;
                REG_MIN_KEEP:     min_keep_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clip incoming range to the window
    assign clip_start = (range_start > window_start_reg) ? range_start : window_start_reg;
    assign clip_end   = (range_end < window_end_reg) ? range_end : window_end_reg;
    assign nonempty   = clip_end > clip_start;
    assign full       = (cnt_reg == CNT_W'(MAX_RANGES));
    assign store      = cmd.load && nonempty && !full;

    // Entries that stay below the insertion point (a prefix, store is sorted)
    always_comb
    begin
        for (int k = 0; k < MAX_RANGES; k++)
            below[k] = (CNT_W'(k) < cnt_reg) && (starts_reg[k] <= clip_start);
    end

    // Store: insert in order on load, shift toward the head on walk
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            if (!below[0])
            begin
                starts_reg[0] <= clip_start;
                ends_reg[0]   <= clip_end;
            end
            for (int k = 1; k < MAX_RANGES; k++)
            begin
                if (!below[k])
                begin
                    if (below[k-1])
                    begin
                        starts_reg[k] <= clip_start;
                        ends_reg[k]   <= clip_end;
                    end
                    else
                    begin
                        starts_reg[k] <= starts_reg[k-1];
                        ends_reg[k]   <= ends_reg[k-1];
                    end
                end
            end
        end
        else if (cmd.walk)
        begin
            for (int k = 0; k < MAX_RANGES - 1; k++)
            begin
                starts_reg[k] <= starts_reg[k+1];
                ends_reg[k]   <= ends_reg[k+1];
            end
        end
    end

    // Fill count and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.close)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (store)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (cmd.walk)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (cmd.load && nonempty && full)
                ovf_reg <= 1'b1;
        end
    end

    // Gap check against the cursor
    assign need       = (min_keep_reg == '0) ? TW'(1) : min_keep_reg;
    assign overlap    = starts_reg[0] <= me_reg;
    assign gap_target = cmd.tail ? window_end_reg : ms_reg;
    assign gap_try    = (cmd.walk && have_reg && !overlap) || (cmd.flush && have_reg) || cmd.tail;
    assign diff       = {1'b0, gap_target} - {1'b0, cursor_reg};
    assign gap_hit    = gap_try && !diff[TW] && (diff[TW-1:0] >= need);
    assign cursor_max = (me_reg > cursor_reg) ? me_reg : cursor_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Merge walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg   <= 1'b0;
            ms_reg     <= '0;
            me_reg     <= '0;
            cursor_reg <= '0;
        end
        else if (cmd.load_last)
        begin
            cursor_reg <= window_start_reg;
            have_reg   <= 1'b0;
        end
        else if (cmd.walk)
        begin
            if (!have_reg)
            begin
                ms_reg   <= starts_reg[0];
                me_reg   <= ends_reg[0];
                have_reg <= 1'b1;
            end
            else if (overlap)
            begin
                if (ends_reg[0] > me_reg)
                    me_reg <= ends_reg[0];
            end
            else
            begin
                cursor_reg <= cursor_max;
                ms_reg     <= starts_reg[0];
                me_reg     <= ends_reg[0];
            end
        end
        else if (cmd.flush)
        begin
            if (have_reg)
                cursor_reg <= cursor_max;
            have_reg <= 1'b0;
        end
    end

    // Pending result and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_start_reg <= '0;
            pend_end_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_start_reg  <= '0;
            out_end_reg    <= '0;
            out_ivalid_reg <= 1'b0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.close)
            begin
                out_valid_reg  <= 1'b1;
                out_start_reg  <= pend_valid_reg ? pend_start_reg : '0;
                out_end_reg    <= pend_valid_reg ? pend_end_reg : '0;
                out_ivalid_reg <= pend_valid_reg;
                out_last_reg   <= 1'b1;
                out_ovf_reg    <= ovf_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (gap_hit)
            begin
                pend_valid_reg <= 1'b1;
                pend_start_reg <= cursor_reg;
                pend_end_reg   <= gap_target;
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_start_reg  <= pend_start_reg;
                    out_end_reg    <= pend_end_reg;
                    out_ivalid_reg <= 1'b1;
                    out_last_reg   <= 1'b0;
                    out_ovf_reg    <= ovf_reg;
                end
                else if (out_ready)
                    out_valid_reg <= 1'b0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.out_free  = out_free;
    assign st.room      = !pend_valid_reg || out_free;

    assign out_valid      = out_valid_reg;
    assign kept_start     = out_start_reg;
    assign kept_end       = out_end_reg;
    assign interval_valid = out_ivalid_reg;
    assign last_result    = out_last_reg;
    assign overflow       = out_ovf_reg;

endmodule
